/* rtl/pds_pkg.sv */
// -----------------------------------------------------------------------------
// pds_pkg: shared types and constants for the playfair digram substitution
// Key square geometry, letter codes, register indexes and cell helpers.
// -----------------------------------------------------------------------------
package pds_pkg;

   localparam int SIDE    = 5;
   localparam int CELLS   = SIDE * SIDE;
   localparam int CODE_W  = 5;
   localparam int POS_W   = $clog2(SIDE);
   localparam int IDX_W   = $clog2(CELLS);
   localparam int PART_W  = 50;
   localparam int TAIL_W  = 25;
   localparam int CSR_W   = PART_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CODE_W-1:0] LETTER_I = CODE_W'(8);
   localparam logic [CODE_W-1:0] LETTER_J = CODE_W'(9);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SQUARE_A  = 2'd0,
      CSR_SQUARE_B  = 2'd1,
      CSR_SQUARE_C  = 2'd2,
      CSR_DIRECTION = 2'd3
   } csr_index_type;

   typedef logic [CELLS-1:0][CODE_W-1:0] square_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } pos_type;

   // row-major cell index
   function automatic logic [IDX_W-1:0] cell_index(input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(row) * IDX_W'(SIDE) + IDX_W'(col);
      return idx;
   endfunction

   // one step round the square side, forward or backward
   function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                 input logic back);
      logic [POS_W-1:0] nxt;
      if (back) begin
         nxt = (p == '0) ? POS_W'(SIDE - 1) : p - POS_W'(1);
      end else begin
         nxt = (p == POS_W'(SIDE - 1)) ? '0 : p + POS_W'(1);
      end
      return nxt;
   endfunction

endpackage

/* rtl/pds_locate.sv */
// -----------------------------------------------------------------------------
// pds_locate: letter position search
// Compares one letter against all cells and returns the row and column of
// the lowest matching cell, with J looked up as I.
// -----------------------------------------------------------------------------
module pds_locate (
   input  logic [pds_pkg::CODE_W-1:0] letter,
   input  pds_pkg::square_type        square,
   output pds_pkg::pos_type           pos
);

   logic [pds_pkg::CODE_W-1:0] key;

   assign key = (letter == pds_pkg::LETTER_J) ? pds_pkg::LETTER_I : letter;

   // lowest cell wins
   always_comb begin
      pos = '0;
      for (int r = pds_pkg::SIDE - 1; r >= 0; r--) begin
         for (int c = pds_pkg::SIDE - 1; c >= 0; c--) begin
            if (square[r * pds_pkg::SIDE + c] == key) begin
               pos.found = 1'b1;
               pos.row   = pds_pkg::POS_W'(r);
               pos.col   = pds_pkg::POS_W'(c);
            end
         end
      end
   end

endmodule

/* rtl/pds_substitute.sv */
// -----------------------------------------------------------------------------
// pds_substitute: digram rule selection and cell read-out
// Applies the row, column or rectangle rule to two located letters and
// reads the substituted letters from the square.
// -----------------------------------------------------------------------------
module pds_substitute (
   input  logic [pds_pkg::CODE_W-1:0] first_raw,
   input  logic [pds_pkg::CODE_W-1:0] second_raw,
   input  pds_pkg::pos_type           pos1,
   input  pds_pkg::pos_type           pos2,
   input  logic                       back,
   input  pds_pkg::square_type        square,
   output logic [pds_pkg::CODE_W-1:0] first_out,
   output logic [pds_pkg::CODE_W-1:0] second_out,
   output logic                       not_found
);

   logic [pds_pkg::POS_W-1:0] or1, oc1, or2, oc2;

   always_comb begin
      priority if (pos1.row == pos2.row) begin
         or1 = pos1.row;
         or2 = pos2.row;
         oc1 = pds_pkg::step_pos(pos1.col, back);
         oc2 = pds_pkg::step_pos(pos2.col, back);
      end else if (pos1.col == pos2.col) begin
         or1 = pds_pkg::step_pos(pos1.row, back);
         or2 = pds_pkg::step_pos(pos2.row, back);
         oc1 = pos1.col;
         oc2 = pos2.col;
      end else begin
         or1 = pos1.row;
         or2 = pos2.row;
         oc1 = pos2.col;
         oc2 = pos1.col;
      end
   end

   assign not_found = !(pos1.found && pos2.found);

   // missing letter passes the raw codes through
   assign first_out  = not_found ? first_raw  : square[pds_pkg::cell_index(or1, oc1)];
   assign second_out = not_found ? second_raw : square[pds_pkg::cell_index(or2, oc2)];

endmodule

/* rtl/playfair_digram_substitution.sv */
// -----------------------------------------------------------------------------
// playfair_digram_substitution: playfair letter pair substitution
// One letter pair per cycle unless rsp stalls, against a configured 5x5 key square.
// -----------------------------------------------------------------------------
//  channel | direction | contents
//  req_*   | in        | tdata: first_letter, second_letter
//  rsp_*   | out       | tdata: first_out, second_out; tuser: not_found
//  csr_*   | in        | square parts a, b, c and direction, write only
//
//  one pair per cycle unless rsp stalls; rsp_tvalid follows the result register
//  stages: input register, square search and rule logic, result register
//  a stalled rsp holds both registers; req_tready falls once both are full
//  synchronous reset empties the pipeline and clears the square and direction
// -----------------------------------------------------------------------------
module playfair_digram_substitution (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,   // first_letter, second_letter
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata,   // first_out, second_out
   output logic [0:0]                   rsp_tuser,   // not_found
   input  logic                         csr_we,
   input  logic [pds_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pds_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int CW = pds_pkg::CODE_W;

   logic [pds_pkg::PART_W-1:0] square_a_ff;
   logic [pds_pkg::PART_W-1:0] square_b_ff;
   logic [pds_pkg::TAIL_W-1:0] square_c_ff;
   logic                       direction_ff;
   pds_pkg::square_type        square;

   logic          in_valid_ff;
   logic [CW-1:0] in_first_ff, in_second_ff;
   logic          out_valid_ff;
   logic [CW-1:0] out_first_ff, out_second_ff;
   logic          out_flag_ff;

   logic          out_load, in_load;
   pds_pkg::pos_type pos1, pos2;
   logic [CW-1:0] first_in, second_in;
   logic          flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         square_a_ff  <= '0;
         square_b_ff  <= '0;
         square_c_ff  <= '0;
         direction_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (pds_pkg::csr_index_type'(csr_index))
            pds_pkg::CSR_SQUARE_A:  square_a_ff  <= csr_wdata;
            pds_pkg::CSR_SQUARE_B:  square_b_ff  <= csr_wdata;
            pds_pkg::CSR_SQUARE_C:  square_c_ff  <= csr_wdata[pds_pkg::TAIL_W-1:0];
            pds_pkg::CSR_DIRECTION: direction_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign square = {square_c_ff, square_b_ff, square_a_ff};

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign in_load    = req_tvalid && req_tready;
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= 1'b1;
         end else if (out_load) begin
            in_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_first_ff  <= req_tdata[CW-1:0];
         in_second_ff <= req_tdata[2*CW-1:CW];
      end
      if (out_load) begin
         out_first_ff  <= first_in;
         out_second_ff <= second_in;
         out_flag_ff   <= flag_in;
      end
   end

   pds_locate u_locate_first (
      .letter (in_first_ff),
      .square (square),
      .pos    (pos1)
   );

   pds_locate u_locate_second (
      .letter (in_second_ff),
      .square (square),
      .pos    (pos2)
   );

   pds_substitute u_substitute (
      .first_raw  (in_first_ff),
      .second_raw (in_second_ff),
      .pos1       (pos1),
      .pos2       (pos2),
      .back       (direction_ff),
      .square     (square),
      .first_out  (first_in),
      .second_out (second_in),
      .not_found  (flag_in)
   );

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {6'd0, out_second_ff, out_first_ff};
   assign rsp_tuser[0] = out_flag_ff;

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_load |=> in_valid_ff && $stable(in_first_ff)
                                   && $stable(in_second_ff))
      else $error("input stage lost a pair while stalled");

   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("result register not valid after load");

   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      out_load && !(pos1.found && pos2.found) |=>
         rsp_tuser[0] && (rsp_tdata[CW-1:0] == $past(in_first_ff)))
      else $error("missing letter not passed through");

endmodule
